### hw/rtl/dmc_pkg.sv
// Shared constants, types and access codes for the direct-mapped data cache.
package dmc_pkg;

    localparam int CACHE_LINES   = 512;   // power of two, 2 to 4096
    localparam int MEMORY_DWORDS = 8192;  // 64 to 1048576

    localparam int IX_W   = $clog2(CACHE_LINES);
    localparam int MEM_AW = $clog2(MEMORY_DWORDS);
    localparam int TAG_W  = 20;
    localparam int DW_W   = 64;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_HALF  = 2'd1;
    localparam logic [1:0] SZ_WORD  = 2'd2;
    localparam logic [1:0] SZ_DWORD = 2'd3;

    typedef struct packed {
        logic [1:0] size;
        logic [2:0] offset;
    } acc_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } tag_entry_t;

endpackage

### hw/rtl/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dmc_align.sv
// Big-endian lane shifter: extracts a load value and merges a store into one dword.
module dmc_align
    import dmc_pkg::*;
(
    input  acc_ctl_t        ctl,
    input  logic [DW_W-1:0] line_dword,
    input  logic [DW_W-1:0] store_data,
    output logic [DW_W-1:0] load_data,
    output logic [DW_W-1:0] merged
);

    logic [2:0]      nb_m1;
    logic [2:0]      off_a;
    logic [2:0]      bsh;
    logic [5:0]      sh;
    logic [DW_W-1:0] mask;
    logic [DW_W-1:0] mask_sh;

    always_comb begin
        unique case (ctl.size)
            SZ_BYTE: begin
                nb_m1 = 3'd0;
                mask  = 64'h0000_0000_0000_00FF;
            end
            SZ_HALF: begin
                nb_m1 = 3'd1;
                mask  = 64'h0000_0000_0000_FFFF;
            end
            SZ_WORD: begin
                nb_m1 = 3'd3;
                mask  = 64'h0000_0000_FFFF_FFFF;
            end
            SZ_DWORD: begin
                nb_m1 = 3'd7;
                mask  = 64'hFFFF_FFFF_FFFF_FFFF;
            end
            default: begin
                nb_m1 = 3'd0;
                mask  = 64'h0000_0000_0000_00FF;
            end
        endcase
        off_a     = ctl.offset & ~nb_m1;
        bsh       = 3'd7 - off_a - nb_m1;
        sh        = {bsh, 3'b000};
        mask_sh   = mask << sh;
        load_data = (line_dword >> sh) & mask;
        merged    = (line_dword & ~mask_sh) | ((store_data & mask) << sh);
    end

endmodule

### hw/rtl/direct_mapped_writeback_dcache.sv
// Direct-mapped write-back data cache with 16-byte lines and internal backing memory.
//
//   channel  dir  ports                      tdata fields, lowest bit up
//   s_       in   s_tvalid s_tready s_tdata  action, access_size, virt_addr_low,
//                                            phys_addr, store_data
//   m_       out  m_tvalid m_tready m_tdata  load_data, was_hit, did_writeback,
//                                            status, zero pad
//
// After reset a clearing pass over max(MEMORY_DWORDS, CACHE_LINES) addresses zeroes the
// backing memory and the tag store; s_tready stays low until it ends.
// A hit or an out-of-range miss is answered from the tag lookup; a clean miss fetches the line
// first, and a dirty miss writes the old line back before that fetch. The line store and backing
// memory each have a single read port, so a miss moves one dword per cycle: two out, two in.
// A result waiting in the output register holds the sequencer in its final state.
module direct_mapped_writeback_dcache
    import dmc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // action, access_size, virt_addr_low, phys_addr, store_data
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // load_data, was_hit, did_writeback, status, pad
);

    localparam int CLR_N = (MEMORY_DWORDS > CACHE_LINES) ? MEMORY_DWORDS : CACHE_LINES;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int LA_W  = IX_W + 1;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_TAG   = 11'b000_0000_0100,
        ST_WB0   = 11'b000_0000_1000,
        ST_WB1   = 11'b000_0001_0000,
        ST_WB2   = 11'b000_0010_0000,
        ST_F0    = 11'b000_0100_0000,
        ST_F1    = 11'b000_1000_0000,
        ST_F2    = 11'b001_0000_0000,
        ST_RD    = 11'b010_0000_0000,
        ST_ACC   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CLR_W-1:0] clr_reg, clr_next;
    logic             act_reg;
    logic [1:0]       size_reg;
    logic [IX_W-1:0]  idx_reg;
    logic [31:0]      paddr_reg;
    logic [DW_W-1:0]  wdata_reg;
    logic             wb_reg, wb_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [71:0]      m_tdata_reg, m_tdata_next;

    logic [IX_W-1:0]   idx_in;
    logic              out_free;
    logic              out_load;
    logic              hit;
    logic              fill_err;
    logic              do_acc;
    logic [28:0]       wb_dw;
    logic              wb_in_range;
    logic [28:0]       fill_dw;
    logic              clr_tag_en;
    logic              clr_bk_en;

    logic              t_we;
    logic [IX_W-1:0]   t_waddr;
    tag_entry_t        t_wdata;
    logic [IX_W-1:0]   t_raddr;
    tag_entry_t        t_rdata;

    logic              d_we;
    logic [LA_W-1:0]   d_waddr;
    logic [DW_W-1:0]   d_wdata;
    logic [LA_W-1:0]   d_raddr;
    logic [DW_W-1:0]   d_rdata;

    logic              b_we;
    logic [MEM_AW-1:0] b_waddr;
    logic [DW_W-1:0]   b_wdata;
    logic [MEM_AW-1:0] b_raddr;
    logic [DW_W-1:0]   b_rdata;

    acc_ctl_t          acc_ctl;
    logic [DW_W-1:0]   acc_load;
    logic [DW_W-1:0]   acc_merged;

    dmc_ram #(.WIDTH($bits(tag_entry_t)), .DEPTH(CACHE_LINES)) u_tag_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    dmc_ram #(.WIDTH(DW_W), .DEPTH(2 * CACHE_LINES)) u_line_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    dmc_ram #(.WIDTH(DW_W), .DEPTH(MEMORY_DWORDS)) u_backing_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dmc_align u_align (
        .ctl        (acc_ctl),
        .line_dword (d_rdata),
        .store_data (wdata_reg),
        .load_data  (acc_load),
        .merged     (acc_merged)
    );

    assign idx_in      = IX_W'({{IX_W{1'b0}}, s_tdata[15:7]});
    assign out_free    = !m_tvalid_reg || m_tready;
    assign hit         = t_rdata.valid && (t_rdata.tag == paddr_reg[31:12]);
    assign fill_dw     = {paddr_reg[31:4], 1'b0};
    assign fill_err    = ({1'b0, fill_dw} + 30'd1) >= 30'(MEMORY_DWORDS);
    assign wb_dw       = {t_rdata.tag, paddr_reg[11:4], (state_reg == ST_WB2)};
    assign wb_in_range = {1'b0, wb_dw} < 30'(MEMORY_DWORDS);
    assign do_acc      = (((state_reg == ST_TAG) && hit) || (state_reg == ST_ACC)) && out_free;
    assign clr_tag_en  = {1'b0, clr_reg} < (CLR_W + 1)'(CACHE_LINES);
    assign clr_bk_en   = {1'b0, clr_reg} < (CLR_W + 1)'(MEMORY_DWORDS);
    assign acc_ctl     = '{size: size_reg, offset: paddr_reg[2:0]};
    assign s_tready    = (state_reg == ST_IDLE);

    always_comb begin
        t_raddr = (state_reg == ST_IDLE) ? idx_in : idx_reg;
        t_we    = 1'b0;
        t_waddr = idx_reg;
        t_wdata = '{valid: 1'b1, dirty: 1'b0, tag: paddr_reg[31:12]};
        if (state_reg == ST_CLEAR) begin
            t_we    = clr_tag_en;
            t_waddr = clr_reg[IX_W-1:0];
            t_wdata = '0;
        end else if (state_reg == ST_F2) begin
            t_we = 1'b1;
        end else if (do_acc && (act_reg == ACT_WRITE)) begin
            t_we          = 1'b1;
            t_wdata.dirty = 1'b1;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: d_raddr = {idx_in, s_tdata[19]};
            ST_WB0:  d_raddr = {idx_reg, 1'b0};
            ST_WB1:  d_raddr = {idx_reg, 1'b1};
            default: d_raddr = {idx_reg, paddr_reg[3]};
        endcase
        d_we    = 1'b0;
        d_waddr = {idx_reg, paddr_reg[3]};
        d_wdata = acc_merged;
        if (state_reg == ST_F1) begin
            d_we    = 1'b1;
            d_waddr = {idx_reg, 1'b0};
            d_wdata = b_rdata;
        end else if (state_reg == ST_F2) begin
            d_we    = 1'b1;
            d_waddr = {idx_reg, 1'b1};
            d_wdata = b_rdata;
        end else if (do_acc && (act_reg == ACT_WRITE)) begin
            d_we = 1'b1;
        end
    end

    always_comb begin
        b_raddr = {fill_dw[MEM_AW-1:1], (state_reg == ST_F1)};
        b_we    = 1'b0;
        b_waddr = wb_dw[MEM_AW-1:0];
        b_wdata = d_rdata;
        if (state_reg == ST_CLEAR) begin
            b_we    = clr_bk_en;
            b_waddr = clr_reg[MEM_AW-1:0];
            b_wdata = '0;
        end else if ((state_reg == ST_WB1) || (state_reg == ST_WB2)) begin
            b_we = wb_in_range;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        wb_next      = wb_reg;
        out_load     = 1'b0;
        m_tdata_next = m_tdata_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                wb_next = 1'b0;
                if (s_tvalid) begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG: begin
                if (hit) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (fill_err) begin
                    if (out_free) begin
                        out_load     = 1'b1;
                        m_tdata_next = {5'b0, 1'b1, 66'b0};
                        state_next   = ST_IDLE;
                    end
                end else if (t_rdata.valid && t_rdata.dirty) begin
                    wb_next    = 1'b1;
                    state_next = ST_WB0;
                end else begin
                    state_next = ST_F0;
                end
            end
            ST_WB0:  state_next = ST_WB1;
            ST_WB1:  state_next = ST_WB2;
            ST_WB2:  state_next = ST_F0;
            ST_F0:   state_next = ST_F1;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_RD;
            ST_RD:   state_next = ST_ACC;
            ST_ACC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (do_acc) begin
            out_load     = 1'b1;
            m_tdata_next = {5'b0, 1'b0, wb_reg, (state_reg == ST_TAG),
                            (act_reg == ACT_WRITE) ? {DW_W{1'b0}} : acc_load};
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            wb_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wb_reg       <= wb_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_tvalid && s_tready) begin
            act_reg   <= s_tdata[0];
            size_reg  <= s_tdata[2:1];
            idx_reg   <= idx_in;
            paddr_reg <= s_tdata[47:16];
            wdata_reg <= s_tdata[111:48];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[66]) |-> (m_tdata[65:0] == 66'b0))
        else $error("error result carries data or flags");

    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[64] && m_tdata[65]))
        else $error("hit and writeback flagged together");

    a_bk_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        b_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_WB1) || (state_reg == ST_WB2)))
        else $error("backing memory written outside clear or writeback");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_acc && (act_reg == ACT_WRITE)) |=> (m_tdata[63:0] == 64'b0))
        else $error("write result returned nonzero load data");
`endif

endmodule
